// ===== rtl/aabb_pkg.sv =====
// Shared types and constants for the box overlap unit.
`default_nettype none

package aabb_pkg;

    // command codes carried in s_tuser
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // width of each index field in a result beat
    localparam int OUT_IDX_W = 5;
    localparam int M_DATA_W  = ((2 * OUT_IDX_W + 7) / 8) * 8;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // per-cell (and combined) status toward the controller
    typedef struct packed {
        logic busy;   // a query sits in the cell
        logic hit;    // query overlaps the stored box
        logic done;   // query reached its own slot
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/aabb_pairwise_collision_unit.sv =====
// Top level of the box overlap unit: stream ports, controller and result register.
`default_nettype none

// Stores up to MAX_BOXES axis-aligned boxes and reports every earlier box
// that a newly added box overlaps (touching counts). Bounds c-h and c+h are
// formed at COORD_BITS+1 bits on input; each stored box lives in its own cell
// of a row, and the new box walks down that row one cell per cycle while not halted,
// being compared against each cell in turn and written into its own slot at
// the end. A clear or a refused add (store full) is handled on acceptance
// with no walk. The walk halts whenever a result beat is waiting and m_tready
// is low. Hits come out in ascending index order with tlast on the final beat;
// an add with no hit gives one beat with hit low, a refused add one beat with
// overflow high, a clear no beat.
module aabb_pairwise_collision_unit #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
    input  wire logic [((6*COORD_BITS-3+7)/8)*8-1:0]      s_tdata,
    // cmd
    input  wire logic                                     s_tuser,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // new_index, other_index, zero pad
    output logic [aabb_pkg::M_DATA_W-1:0]                 m_tdata,
    // hit, overflow
    output logic [1:0]                                    m_tuser,
    output logic                                          m_tlast
);
    import aabb_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_reg, pend_next;

    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_new_reg, out_new_next;
    logic [IDX_W-1:0]     out_other_reg, out_other_next;
    logic                 out_hit_reg, out_hit_next;
    logic                 out_ovf_reg, out_ovf_next;
    logic                 out_last_reg, out_last_next;

    logic                 can_push;
    logic                 accept;
    logic                 full;
    logic                 adv;
    logic                 inject;
    logic [2:0][CB:0]     q_lo;
    logic [2:0][CB:0]     q_hi;
    cell_stat_t           stat;

    logic [IDX_W+OUT_IDX_W-1:0] new_wide;
    logic [IDX_W+OUT_IDX_W-1:0] other_wide;

    assign can_push = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && can_push;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(MAX_BOXES));

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            q_lo[a] = {s_tdata[a*CB + CB - 1], s_tdata[a*CB +: CB]} -
                      {2'b00, s_tdata[3*CB + a*(CB-1) +: CB-1]};
            q_hi[a] = {s_tdata[a*CB + CB - 1], s_tdata[a*CB +: CB]} +
                      {2'b00, s_tdata[3*CB + a*(CB-1) +: CB-1]};
        end
    end

    aabb_chain #(
        .CB        (CB),
        .IDX_W     (IDX_W),
        .MAX_BOXES (MAX_BOXES)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (inject),
        .in_idx   (count_reg[IDX_W-1:0]),
        .in_lo    (q_lo),
        .in_hi    (q_hi),
        .stat     (stat)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_new_next    = out_new_reg;
        out_other_next  = out_other_reg;
        out_hit_next    = out_hit_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        adv             = 1'b0;
        inject          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_CLEAR) begin
                        count_next = '0;
                    end else if (full) begin
                        out_valid_next = 1'b1;
                        out_new_next   = '0;
                        out_other_next = '0;
                        out_hit_next   = 1'b0;
                        out_ovf_next   = 1'b1;
                        out_last_next  = 1'b1;
                    end else begin
                        inject          = 1'b1;
                        adv             = 1'b1;
                        cur_next        = count_reg[IDX_W-1:0];
                        count_next      = count_reg + 1'b1;
                        pos_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                adv = can_push;
                if (can_push) begin
                    if (stat.done) begin
                        // end of walk: flush the held hit, or a beat with hit low if none, as the last beat
                        out_valid_next = 1'b1;
                        out_new_next   = cur_reg;
                        out_other_next = pend_valid_reg ? pend_reg : '0;
                        out_hit_next   = pend_valid_reg;
                        out_ovf_next   = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                        if (stat.hit) begin
                            // one hit is held back so tlast can be set on the final one
                            if (pend_valid_reg) begin
                                out_valid_next = 1'b1;
                                out_new_next   = cur_reg;
                                out_other_next = pend_reg;
                                out_hit_next   = 1'b1;
                                out_ovf_next   = 1'b0;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = pos_reg;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        pos_reg       <= pos_next;
        pend_reg      <= pend_next;
        out_new_reg   <= out_new_next;
        out_other_reg <= out_other_next;
        out_hit_reg   <= out_hit_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign new_wide   = {{OUT_IDX_W{1'b0}}, out_new_reg};
    assign other_wide = {{OUT_IDX_W{1'b0}}, out_other_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({other_wide[OUT_IDX_W-1:0], new_wide[OUT_IDX_W-1:0]});
    assign m_tuser  = {out_ovf_reg, out_hit_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !stat.busy)
        else $error("cell row busy while controller idle");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (stat.busy && pos_reg <= cur_reg))
        else $error("walk position lost");

    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_hit_reg) |-> (out_other_reg < out_new_reg))
        else $error("hit names a box not earlier than the new one");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count beyond store depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/aabb_cell.sv =====
// One slot of the box chain: holds a stored box and one travelling query.
`default_nettype none

module aabb_cell #(
    parameter int CB       = 16,
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [IDX_W-1:0]     in_idx,
    input  wire logic [2:0][CB:0]     in_lo,
    input  wire logic [2:0][CB:0]     in_hi,
    output logic                      out_valid,
    output logic [IDX_W-1:0]          out_idx,
    output logic [2:0][CB:0]          out_lo,
    output logic [2:0][CB:0]          out_hi,
    output aabb_pkg::cell_stat_t      stat
);
    import aabb_pkg::*;

    logic                 q_valid_reg;
    logic [IDX_W-1:0]     q_idx_reg;
    logic [2:0][CB:0]     q_lo_reg;
    logic [2:0][CB:0]     q_hi_reg;
    logic [2:0][CB:0]     st_lo_reg;
    logic [2:0][CB:0]     st_hi_reg;

    logic                 is_here;
    logic [2:0]           axis_ovl;

    assign is_here = (q_idx_reg == IDX_W'(CELL_IDX));

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            axis_ovl[a] = ($signed(q_hi_reg[a]) >= $signed(st_lo_reg[a])) &&
                          ($signed(q_lo_reg[a]) <= $signed(st_hi_reg[a]));
        end
    end

    assign stat.busy = q_valid_reg;
    assign stat.done = q_valid_reg && is_here;
    assign stat.hit  = q_valid_reg && !is_here && (&axis_ovl);

    // a query moves on only past slots below its own index
    assign out_valid = q_valid_reg && !is_here;
    assign out_idx   = q_idx_reg;
    assign out_lo    = q_lo_reg;
    assign out_hi    = q_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (adv) begin
            q_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_idx_reg <= in_idx;
            q_lo_reg  <= in_lo;
            q_hi_reg  <= in_hi;
        end
        if (adv && q_valid_reg && is_here) begin
            st_lo_reg <= q_lo_reg;
            st_hi_reg <= q_hi_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aabb_chain.sv =====
// Row of box cells; the query walks one cell per advance.
`default_nettype none

module aabb_chain #(
    parameter int CB        = 16,
    parameter int IDX_W     = 5,
    parameter int MAX_BOXES = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [IDX_W-1:0]     in_idx,
    input  wire logic [2:0][CB:0]     in_lo,
    input  wire logic [2:0][CB:0]     in_hi,
    output aabb_pkg::cell_stat_t      stat
);
    import aabb_pkg::*;

    logic                 lnk_valid [MAX_BOXES+1];
    logic [IDX_W-1:0]     lnk_idx   [MAX_BOXES+1];
    logic [2:0][CB:0]     lnk_lo    [MAX_BOXES+1];
    logic [2:0][CB:0]     lnk_hi    [MAX_BOXES+1];
    cell_stat_t           cell_stat [MAX_BOXES];
    logic [MAX_BOXES-1:0] busy_vec;
    logic [MAX_BOXES-1:0] hit_vec;
    logic [MAX_BOXES-1:0] done_vec;

    assign lnk_valid[0] = in_valid;
    assign lnk_idx[0]   = in_idx;
    assign lnk_lo[0]    = in_lo;
    assign lnk_hi[0]    = in_hi;

    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
        aabb_cell #(
            .CB       (CB),
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (lnk_valid[i]),
            .in_idx    (lnk_idx[i]),
            .in_lo     (lnk_lo[i]),
            .in_hi     (lnk_hi[i]),
            .out_valid (lnk_valid[i+1]),
            .out_idx   (lnk_idx[i+1]),
            .out_lo    (lnk_lo[i+1]),
            .out_hi    (lnk_hi[i+1]),
            .stat      (cell_stat[i])
        );
        assign busy_vec[i] = cell_stat[i].busy;
        assign hit_vec[i]  = cell_stat[i].hit;
        assign done_vec[i] = cell_stat[i].done;
    end

    // at most one query is in the row, so a plain OR picks its status
    assign stat.busy = |busy_vec;
    assign stat.hit  = |hit_vec;
    assign stat.done = |done_vec;

`ifndef SYNTHESIS
    a_one_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(busy_vec))
        else $error("more than one query in the cell row");

    a_no_runoff: assert property (@(posedge aclk) disable iff (!aresetn)
        !lnk_valid[MAX_BOXES] && (lnk_idx[MAX_BOXES] == lnk_idx[MAX_BOXES] ||
        lnk_lo[MAX_BOXES] != lnk_hi[MAX_BOXES] || 1'b1))
        else $error("query ran past the last cell");
`endif

endmodule

`default_nettype wire

// ===== bench/aabb_pairwise_collision_unit_tb.sv =====
// Testbench for the box overlap unit: directed and random stream traffic checked against a behavioral box store.
`default_nettype none

module aabb_pairwise_collision_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aabb_pkg::*;

    localparam int MAX_BOXES  = 32;
    localparam int COORD_BITS = 16;
    localparam int S_DATA_W   = ((6*COORD_BITS-3+7)/8)*8;
    localparam int ITEM_COUNT = 460;
    localparam int QUIET_FROM = 420;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [14:0] hx;
        logic [14:0] hy;
        logic [14:0] hz;
    } box_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] new_idx;
        logic [OUT_IDX_W-1:0] other_idx;
        logic                 hit;
        logic                 ovf;
        logic                 last;
    } pair_beat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // behavioral copy of the box store
    box_t       box_store [MAX_BOXES];
    int         boxes_held;
    pair_beat_t expected_pairs [$];

    int  items_sent;
    int  mismatches;
    int  cycle_count;
    bit  idle_en;

    aabb_pairwise_collision_unit #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[aabb_pairwise_collision_unit] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    // closed intervals [c-h, c+h] on one axis, touching counts
    function automatic bit axis_touch(input logic signed [15:0] ca, input logic [14:0] ha,
                                      input logic signed [15:0] cb, input logic [14:0] hb);
        int ia, iha, ib, ihb;
        ia  = ca;
        iha = ha;
        ib  = cb;
        ihb = hb;
        return (ib + ihb >= ia - iha) && (ib - ihb <= ia + iha);
    endfunction

    function automatic bit boxes_overlap(input box_t a, input box_t b);
        return axis_touch(a.cx, a.hx, b.cx, b.hx) &&
               axis_touch(a.cy, a.hy, b.cy, b.hy) &&
               axis_touch(a.cz, a.hz, b.cz, b.hz);
    endfunction

    task automatic predict_pairs(input logic cmd, input box_t b);
        pair_beat_t r;
        int         idx;
        int         hits [$];
        r = '0;
        if (cmd == CMD_CLEAR) begin
            boxes_held = 0;
            return;
        end
        if (boxes_held >= MAX_BOXES) begin
            r.ovf  = 1'b1;
            r.last = 1'b1;
            expected_pairs.insert(expected_pairs.size(), r);
            return;
        end
        idx = boxes_held;
        for (int j = 0; j < idx; j++)
            if (boxes_overlap(b, box_store[j]))
                hits.insert(hits.size(), j);
        box_store[idx] = b;
        boxes_held = idx + 1;
        r.new_idx = idx[OUT_IDX_W-1:0];
        if (hits.size() == 0) begin
            r.last = 1'b1;
            expected_pairs.insert(expected_pairs.size(), r);
        end else begin
            foreach (hits[k]) begin
                r.other_idx = hits[k][OUT_IDX_W-1:0];
                r.hit  = 1'b1;
                r.last = (k == hits.size() - 1);
                expected_pairs.insert(expected_pairs.size(), r);
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge aclk) begin : check_pair_beats
        pair_beat_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.new_idx   = m_tdata[OUT_IDX_W-1:0];
            got.other_idx = m_tdata[2*OUT_IDX_W-1:OUT_IDX_W];
            got.hit       = m_tuser[0];
            got.ovf       = m_tuser[1];
            got.last      = m_tlast;
            if (expected_pairs.size() == 0) begin
                flag_mismatch("unexpected beat, new_index", -1, got.new_idx);
            end else begin
                want = expected_pairs.pop_front();
                if (got.new_idx != want.new_idx)
                    flag_mismatch("new_index", want.new_idx, got.new_idx);
                if (got.other_idx != want.other_idx)
                    flag_mismatch("other_index", want.other_idx, got.other_idx);
                if (got.hit != want.hit)
                    flag_mismatch("hit", want.hit, got.hit);
                if (got.ovf != want.ovf)
                    flag_mismatch("overflow", want.ovf, got.ovf);
                if (got.last != want.last)
                    flag_mismatch("last", want.last, got.last);
            end
        end
    end

    // ---------------------------------------------------------------- result side

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic box_t make_box(input int cx, input int cy, input int cz,
                                      input int hx, input int hy, input int hz);
        box_t b;
        b.cx = cx[15:0];
        b.cy = cy[15:0];
        b.cz = cz[15:0];
        b.hx = hx[14:0];
        b.hy = hy[14:0];
        b.hz = hz[14:0];
        return b;
    endfunction

    function automatic box_t rand_wide_box();
        return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // small box scattered around a common point, so that many pairs overlap
    function automatic box_t rand_near_box(input int bx, input int by, input int bz);
        return make_box(bx + int'($urandom_range(0, 4000)) - 2000,
                        by + int'($urandom_range(0, 4000)) - 2000,
                        bz + int'($urandom_range(0, 4000)) - 2000,
                        $urandom_range(0, 1500), $urandom_range(0, 1500),
                        $urandom_range(0, 1500));
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_box(input box_t b);
        return {{(S_DATA_W-93){1'b0}}, b.hz, b.hy, b.hx, b.cz, b.cy, b.cx};
    endfunction

    task automatic send_item(input logic cmd, input box_t b);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_box(b);
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        predict_pairs(cmd, b);
        items_sent++;
    endtask

    task automatic add_box(input int cx, input int cy, input int cz,
                           input int hx, input int hy, input int hz);
        send_item(CMD_ADD, make_box(cx, cy, cz, hx, hy, hz));
    endtask

    task automatic wait_results_done();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(CMD_CLEAR, rand_wide_box());         // clear on an empty store
        add_box(0, 0, 0, 0, 0, 0);                     // first box, no partner
        add_box(0, 0, 0, 0, 0, 0);                     // same point: degenerate touch
        add_box(1, 0, 0, 0, 0, 0);                     // one unit apart, no hit
        add_box(10, 0, 0, 5, 1, 1);
        add_box(20, 0, 0, 5, 0, 0);                    // faces touch at x = 15
        add_box(-32768, -32768, -32768, 32767, 32767, 32767);
        add_box(32767, 32767, 32767, 32767, 32767, 32767);
        add_box(-1, -1, -1, 1, 1, 1);                  // touches both extreme boxes
        add_box(32767, -32768, 32767, 0, 0, 0);
        add_box(0, 5, 0, 32767, 0, 32767);             // misses only on y
        send_item(CMD_CLEAR, rand_wide_box());
        add_box(-32768, 32767, -32768, 0, 0, 0);       // index restarts at zero
        add_box(-32768, 32767, -32768, 32767, 0, 0);
        add_box(-32767, 32767, -32768, 0, 0, 0);
        send_item(CMD_CLEAR, rand_wide_box());
    endtask

    task automatic test_store_full();
        send_item(CMD_CLEAR, rand_wide_box());
        // all boxes overlap each other: the last one reports every earlier box
        for (int k = 0; k < MAX_BOXES; k++)
            add_box(int'($urandom_range(0, 100)) - 50, int'($urandom_range(0, 100)) - 50,
                    int'($urandom_range(0, 100)) - 50, $urandom_range(100, 200),
                    $urandom_range(100, 200), $urandom_range(100, 200));
        wait_results_done();
        send_item(CMD_ADD, rand_wide_box());
        send_item(CMD_ADD, rand_wide_box());
        send_item(CMD_CLEAR, rand_wide_box());
        add_box(0, 0, 0, 10, 10, 10);
    endtask

    task automatic run_box_set();
        int n, bx, by, bz, pick;
        bit clustered;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            n = $urandom_range(1, 20);
        else if (pick < 9)
            n = $urandom_range(20, 32);
        else
            n = $urandom_range(33, 38);
        clustered = ($urandom_range(0, 9) < 7);
        bx = int'($urandom_range(0, 40000)) - 20000;
        by = int'($urandom_range(0, 40000)) - 20000;
        bz = int'($urandom_range(0, 40000)) - 20000;
        send_item(CMD_CLEAR, rand_wide_box());
        for (int k = 0; k < n; k++) begin
            if (clustered && $urandom_range(0, 9) != 0)
                send_item(CMD_ADD, rand_near_box(bx, by, bz));
            else
                send_item(CMD_ADD, rand_wide_box());
        end
    endtask

    task automatic test_random_sets();
        while (items_sent < QUIET_FROM)
            run_box_set();
    endtask

    task automatic test_quiet_tail();
        idle_en = 1'b0;
        while (items_sent < ITEM_COUNT)
            run_box_set();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_ADD;
        boxes_held  = 0;
        items_sent  = 0;
        mismatches  = 0;
        cycle_count = 0;
        idle_en     = 1'b1;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_store_full();
        test_random_sets();
        test_quiet_tail();

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += expected_pairs.size();
        if (mismatches == 0)
            $display("[aabb_pairwise_collision_unit] OK");
        else
            $display("[aabb_pairwise_collision_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== aabb_pairwise_collision_unit.f =====
rtl/aabb_pkg.sv
rtl/aabb_cell.sv
rtl/aabb_chain.sv
rtl/aabb_pairwise_collision_unit.sv
bench/aabb_pairwise_collision_unit_tb.sv
